### design/generational_handle_allocator_core_assert.svh
// assertion macros for the handle allocator checker
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_CORE_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GHA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define GHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/gha_pkg.sv
// shared types and constants for the generational handle allocator
`default_nettype none

package gha_pkg;

  // default slot count and fixed field widths
  localparam int SLOTS_DEF = 1024;
  localparam int GEN_W     = 16;
  localparam int MODE_W    = 3;
  localparam int STATUS_W  = 2;

  // max_generation after reset
  localparam logic [GEN_W-1:0] MAX_GEN_RST = 16'd4095;

  // first generation of a fresh slot
  localparam logic [GEN_W-1:0] GEN_FIRST = 16'd1;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_CREATE   = 3'd0,
    MODE_DESTROY  = 3'd1,
    MODE_VALIDATE = 3'd2,
    MODE_LOOKUP   = 3'd3,
    MODE_CLEAR    = 3'd4
  } mode_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

endpackage

`default_nettype wire

### design/generational_handle_allocator_core.sv
// generational handle allocator: free stack, generation memory and result register
//
//  channel  direction  handshake              word
//  in       sink       in_valid / in_stall    mode, handle_index, handle_generation
//  out      source     out_valid / out_stall  status, slot_index, slot_generation, live_count
//  cfg      sink       cfg_valid / cfg_ready  cfg_data (max_generation)
//
// one word per cycle while out_stall is low: a word sits in the input stage, where the generation
// memory read issued on acceptance is checked and the state is updated, then moves to
// the result register.
// the free stack keeps its top two entries in flops so a pop takes its slot from a flop.
// reset clears counters and valid flags and restores max_generation; memories need no clearing pass.
// out_stall holds the result register; the input stage then holds one more word.
`default_nettype none

module generational_handle_allocator_core import gha_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IW = $clog2(SLOTS),
  localparam int CW = IW + 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [GEN_W-1:0]  cfg_data,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [IW-1:0]     handle_index,
  input  wire logic [GEN_W-1:0]  handle_generation,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [STATUS_W-1:0]    status,
  output logic [IW-1:0]          slot_index,
  output logic [GEN_W-1:0]       slot_generation,
  output logic [CW-1:0]          live_count
);

  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] TWO_C   = CW'(2);
  localparam logic [CW-1:0] THREE_C = CW'(3);

  // configuration register
  logic [GEN_W-1:0] max_gen;

  // input stage
  logic             s1_valid;
  mode_t            s1_mode;
  logic [IW-1:0]    s1_idx;
  logic [GEN_W-1:0] s1_gen;
  logic             s1_adv;
  logic             in_acc;
  logic             commit;

  // generation memory and forwarding
  logic [GEN_W-1:0] gen_mem [SLOTS];
  logic [GEN_W-1:0] gen_q;
  logic             fwd_hit;
  logic [GEN_W-1:0] fwd_data;
  logic [GEN_W-1:0] gen_cur;
  logic             gen_we;
  logic [IW-1:0]    gen_waddr;
  logic [GEN_W-1:0] gen_wdata;
  logic [IW-1:0]    gen_raddr;

  // free stack: top two entries in flops, the rest in memory
  logic [IW-1:0]    stk_mem [SLOTS];
  logic [IW-1:0]    stk_q;
  logic [IW-1:0]    t0;
  logic [IW-1:0]    t1_reg;
  logic             t1_sel;
  logic [IW-1:0]    t1_eff;
  logic [IW-1:0]    t0_next;

  // counters
  logic [CW-1:0]    free_top;
  logic [CW-1:0]    free_top_next;
  logic [CW-1:0]    slots_used;
  logic [CW-1:0]    slots_used_next;
  logic [CW-1:0]    live_total;
  logic [CW-1:0]    live_total_next;

  // per-word decisions
  logic             in_range;
  logic             handle_ok;
  logic [GEN_W:0]   gen_inc;
  logic [GEN_W-1:0] gen_bumped;
  logic             do_pop;
  logic             do_push;
  logic             do_fresh;
  logic             do_clear;
  status_t          res_status;
  logic [IW-1:0]    res_idx;
  logic [GEN_W-1:0] res_gen;

  // handshakes
  assign cfg_ready = 1'b1;
  assign s1_adv    = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !s1_adv;
  assign in_acc    = in_valid && !in_stall;
  assign commit    = s1_valid && s1_adv;

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      max_gen <= MAX_GEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_gen <= cfg_data;
    end
  end

  // input stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // input stage word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode <= mode_t'(mode);
      s1_idx  <= handle_index;
      s1_gen  <= handle_generation;
    end
  end

  // handle check and generation bump
  assign gen_cur    = fwd_hit ? fwd_data : gen_q;
  assign t1_eff     = t1_sel ? stk_q : t1_reg;
  assign in_range   = {1'b0, s1_idx} < slots_used;
  assign handle_ok  = (s1_gen != '0) && in_range && (gen_cur == s1_gen);
  assign gen_inc    = {1'b0, gen_cur} + {{GEN_W{1'b0}}, 1'b1};
  assign gen_bumped = (gen_inc > {1'b0, max_gen}) ? GEN_FIRST : gen_inc[GEN_W-1:0];

  // operation decode
  always_comb begin
    res_status = ST_INVALID;
    res_idx    = '0;
    res_gen    = '0;
    do_pop     = 1'b0;
    do_push    = 1'b0;
    do_fresh   = 1'b0;
    do_clear   = 1'b0;
    unique case (s1_mode)
      MODE_CREATE: begin
        if (free_top != '0) begin
          do_pop     = 1'b1;
          res_status = ST_OK;
          res_idx    = t0;
          res_gen    = gen_cur;
        end else if (slots_used != SLOTS_C) begin
          do_fresh   = 1'b1;
          res_status = ST_OK;
          res_idx    = slots_used[IW-1:0];
          res_gen    = GEN_FIRST;
        end else begin
          res_status = ST_FULL;
        end
      end
      MODE_DESTROY: begin
        if (handle_ok && free_top != SLOTS_C) begin
          do_push    = 1'b1;
          res_status = ST_OK;
          res_idx    = s1_idx;
          res_gen    = gen_bumped;
        end
      end
      MODE_VALIDATE: begin
        if (handle_ok) begin
          res_status = ST_OK;
          res_idx    = s1_idx;
          res_gen    = s1_gen;
        end
      end
      MODE_LOOKUP: begin
        if (in_range) begin
          res_status = ST_OK;
          res_idx    = s1_idx;
          res_gen    = gen_cur;
        end
      end
      MODE_CLEAR: begin
        do_clear   = 1'b1;
        res_status = ST_OK;
      end
      default: begin
        res_status = ST_INVALID;
      end
    endcase
  end

  // next counter and stack-top values
  always_comb begin
    free_top_next   = free_top;
    slots_used_next = slots_used;
    live_total_next = live_total;
    t0_next         = t0;
    if (commit) begin
      if (do_clear) begin
        free_top_next   = '0;
        slots_used_next = '0;
        live_total_next = '0;
      end
      if (do_pop) begin
        free_top_next   = free_top - ONE_C;
        live_total_next = live_total + ONE_C;
        t0_next         = t1_eff;
      end
      if (do_fresh) begin
        slots_used_next = slots_used + ONE_C;
        live_total_next = live_total + ONE_C;
      end
      if (do_push) begin
        free_top_next = free_top + ONE_C;
        t0_next       = s1_idx;
        if (live_total != '0) begin
          live_total_next = live_total - ONE_C;
        end
      end
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      free_top   <= '0;
      slots_used <= '0;
      live_total <= '0;
    end else begin
      free_top   <= free_top_next;
      slots_used <= slots_used_next;
      live_total <= live_total_next;
    end
  end

  // stack top flops
  always_ff @(posedge clk) begin
    t0 <= t0_next;
    if (commit && do_push) begin
      t1_reg <= t0;
      t1_sel <= 1'b0;
    end else if (commit && do_pop) begin
      t1_sel <= 1'b1;
    end
  end

  // stack memory: spill second entry on push, refill it on pop
  always_ff @(posedge clk) begin
    if (commit && do_push && free_top >= TWO_C) begin
      stk_mem[IW'(free_top - TWO_C)] <= t1_eff;
    end
    if (commit && do_pop && free_top >= THREE_C) begin
      stk_q <= stk_mem[IW'(free_top - THREE_C)];
    end
  end

  // generation memory write and read for the next word
  assign gen_we    = commit && (do_fresh || do_push);
  assign gen_waddr = do_fresh ? slots_used[IW-1:0] : s1_idx;
  assign gen_wdata = do_fresh ? GEN_FIRST : gen_bumped;
  assign gen_raddr = (mode == MODE_CREATE) ? t0_next : handle_index;

  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    if (in_acc) begin
      gen_q <= gen_mem[gen_raddr];
    end
  end

  // bypass for a read that meets a write in the same cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_hit  <= gen_we && (gen_waddr == gen_raddr);
      fwd_data <= gen_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status          <= res_status;
      slot_index      <= res_idx;
      slot_generation <= res_gen;
      live_count      <= live_total_next;
    end
  end

endmodule

`default_nettype wire

### design/gha_checker.sv
// port-level checker for the generational handle allocator, with its bind
`default_nettype none

`include "generational_handle_allocator_core_assert.svh"

module gha_checker import gha_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IW = $clog2(SLOTS),
  localparam int CW = IW + 1
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [IW-1:0]     slot_index,
  input wire logic [GEN_W-1:0]  slot_generation,
  input wire logic [CW-1:0]     live_count
);

  // a stalled result word holds
  `GHA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(status) && $stable(slot_index) &&
    $stable(slot_generation) && $stable(live_count),
    "stalled result word changed")

  // input backs up only behind a stalled full result register
  `GHA_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, out_valid && out_stall,
    "input stalled without output backpressure")

  // failed operations report a zero slot
  `GHA_ASSERT_NOW(a_fail_zero, clk, rst, out_valid && status != ST_OK,
    slot_index == '0 && slot_generation == '0, "failed word carries a slot")

  // an ok word with generation zero only comes from clear
  `GHA_ASSERT_NOW(a_clear_zero, clk, rst,
    out_valid && status == ST_OK && slot_generation == '0,
    live_count == '0 && slot_index == '0, "ok word with null generation is not a clear")

endmodule

bind generational_handle_allocator_core gha_checker #(.SLOTS(SLOTS)) u_gha_checker (.*);

`default_nettype wire

### bench/generational_handle_allocator_core_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the generational handle allocator core
module generational_handle_allocator_core_tb;
  import gha_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam int IW = $clog2(SLOTS);
  localparam int CW = IW + 1;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DIR_N = 25;
  localparam int RAND_PER_PHASE = 60;
  localparam int SETTLE = 8;
  localparam int REPORT_MAX = 10;

  // mode codes with no operation behind them
  localparam logic [MODE_W-1:0] MODE_SPARE5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  localparam logic [IW-1:0] IDX_TOP = IW'(SLOTS - 1);
  localparam logic [GEN_W-1:0] GEN_TOP = '1;

  typedef struct packed {
    status_t          st;
    logic [IW-1:0]    idx;
    logic [GEN_W-1:0] gen;
    logic [CW-1:0]    live;
  } result_t;

  typedef struct packed {
    logic [MODE_W-1:0] md;
    logic [IW-1:0]     idx;
    logic [GEN_W-1:0]  gen;
    logic              typed;
    result_t           want;
  } stim_row_t;

  localparam result_t UNTYPED = '{ST_OK, '0, '0, '0};

  // dut ports
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [GEN_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MODE_W-1:0] mode = '0;
  logic [IW-1:0] handle_index = '0;
  logic [GEN_W-1:0] handle_generation = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [IW-1:0] slot_index;
  logic [GEN_W-1:0] slot_generation;
  logic [CW-1:0] live_count;

  // allocator state as the bench predicts it
  logic [GEN_W-1:0] gen_mem [SLOTS];
  logic [IW-1:0] free_stk [SLOTS];
  bit slot_live [SLOTS];
  int free_top = 0;
  int slots_used = 0;
  int live_total = 0;
  logic [GEN_W-1:0] max_gen = MAX_GEN_RST;

  result_t results_due [$];
  int bad_words = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  generational_handle_allocator_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .handle_index(handle_index),
    .handle_generation(handle_generation),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .slot_index(slot_index),
    .slot_generation(slot_generation),
    .live_count(live_count)
  );

  always #5 clk = ~clk;

  // predict one result word and advance the allocator state
  function automatic result_t apply_op(logic [MODE_W-1:0] md, logic [IW-1:0] idx,
                                       logic [GEN_W-1:0] gen);
    result_t r;
    int bumped;
    bit known;
    r = '{ST_INVALID, '0, '0, '0};
    known = (gen != '0) && (int'(idx) < slots_used) && (gen_mem[idx] == gen);
    case (md)
      MODE_CREATE: begin
        // newest freed slot first, then a fresh one
        if (free_top > 0) begin
          free_top--;
          r.idx = free_stk[free_top];
        end else if (slots_used < SLOTS) begin
          r.idx = IW'(slots_used);
          gen_mem[slots_used] = GEN_FIRST;
          slots_used++;
        end else begin
          r.st = ST_FULL;
        end
        if (r.st != ST_FULL) begin
          r.gen = gen_mem[r.idx];
          live_total++;
          slot_live[r.idx] = 1'b1;
          r.st = ST_OK;
        end
      end
      MODE_DESTROY: begin
        if (known && free_top < SLOTS) begin
          // bump on a wide value so the top generation wraps to one
          bumped = int'(gen_mem[idx]) + 1;
          if (bumped > int'(max_gen)) bumped = 1;
          gen_mem[idx] = GEN_W'(bumped);
          free_stk[free_top] = idx;
          free_top++;
          if (live_total > 0) live_total--;
          slot_live[idx] = 1'b0;
          r.st = ST_OK;
          r.idx = idx;
          r.gen = GEN_W'(bumped);
        end
      end
      MODE_VALIDATE: begin
        if (known) begin
          r.st = ST_OK;
          r.idx = idx;
          r.gen = gen;
        end
      end
      MODE_LOOKUP: begin
        if (int'(idx) < slots_used) begin
          r.st = ST_OK;
          r.idx = idx;
          r.gen = gen_mem[idx];
        end
      end
      MODE_CLEAR: begin
        free_top = 0;
        slots_used = 0;
        live_total = 0;
        foreach (slot_live[j]) slot_live[j] = 1'b0;
        r.st = ST_OK;
      end
      default: begin
      end
    endcase
    r.live = CW'(live_total);
    return r;
  endfunction

  function automatic stim_row_t op_row(logic [MODE_W-1:0] md, logic [IW-1:0] idx,
                                       logic [GEN_W-1:0] gen);
    op_row = '{md, idx, gen, 1'b0, UNTYPED};
  endfunction

  // mostly well-formed traffic on handed-out slots, some noise
  function automatic stim_row_t pick_random_op();
    stim_row_t row;
    int roll;
    int step;
    int top;
    logic [IW-1:0] slot;
    logic [GEN_W-1:0] cur_gen;
    row = op_row(MODE_CREATE, IW'($urandom), GEN_W'($urandom));
    roll = $urandom_range(0, 99);
    slot = (slots_used > 0) ? IW'($urandom_range(0, slots_used - 1)) : '0;
    // walk forward to a live slot if there is one
    step = 0;
    while (step < slots_used && !slot_live[slot]) begin
      slot = (int'(slot) + 1 == slots_used) ? '0 : slot + 1'b1;
      step++;
    end
    cur_gen = (slots_used > 0) ? gen_mem[slot] : GEN_W'($urandom);
    if (roll < 40) begin
      row.md = MODE_CREATE;
    end else if (roll < 60) begin
      row = op_row(MODE_DESTROY, slot, cur_gen);
    end else if (roll < 72) begin
      // current handle, or one a few generations off
      row = op_row(MODE_VALIDATE, slot,
                   (roll < 68) ? cur_gen : cur_gen + GEN_W'($urandom_range(1, 3)));
    end else if (roll < 82) begin
      top = (slots_used + 1 < SLOTS) ? slots_used + 1 : SLOTS - 1;
      row = op_row(MODE_LOOKUP, IW'($urandom_range(0, top)), GEN_W'($urandom));
    end else if (roll < 99) begin
      row.md = MODE_W'($urandom_range(0, 7));
      if (row.md == MODE_CLEAR) row.md = MODE_SPARE5;
    end else begin
      row.md = MODE_CLEAR;
    end
    return row;
  endfunction

  // present one request word, wait for acceptance, queue its result
  task automatic send_word(input stim_row_t row);
    result_t due;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      mode <= MODE_W'($urandom);
      handle_index <= IW'($urandom);
      handle_generation <= GEN_W'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= row.md;
    handle_index <= row.idx;
    handle_generation <= row.gen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due = apply_op(row.md, row.idx, row.gen);
    if (row.typed) due = row.want;
    results_due = {results_due, due};
  endtask

  task automatic random_batch(input int count);
    for (int n = 0; n < count; n++) send_word(pick_random_op());
  endtask

  // stop sending and let every outstanding result drain
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_max_gen(input logic [GEN_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    max_gen = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver back-pressure
  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  // result checker
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        if (bad_words < REPORT_MAX)
          $display("unexpected result word: status %0d idx %0d gen %0d live %0d",
                   status, slot_index, slot_generation, live_count);
        bad_words++;
      end else begin
        want = results_due.pop_front();
        if (status !== want.st || slot_index !== want.idx ||
            slot_generation !== want.gen || live_count !== want.live) begin
          if (bad_words < REPORT_MAX)
            $display({"mismatch: expected status %0d idx %0d gen %0d live %0d, ",
                      "got status %0d idx %0d gen %0d live %0d"},
                     want.st, want.idx, want.gen, want.live,
                     status, slot_index, slot_generation, live_count);
          bad_words++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : run
    stim_row_t dir_rows [DIR_N];
    int k;
    dir_rows = '{
      // nothing handed out yet: null handle, empty lookup, top index and generation
      '{MODE_VALIDATE, '0, '0, 1'b1, '{ST_INVALID, '0, '0, '0}},
      '{MODE_LOOKUP, '0, '0, 1'b1, '{ST_INVALID, '0, '0, '0}},
      '{MODE_DESTROY, IDX_TOP, GEN_TOP, 1'b1, '{ST_INVALID, '0, '0, '0}},
      // fresh slots start at generation one
      '{MODE_CREATE, '0, '0, 1'b1, '{ST_OK, 10'd0, 16'd1, 11'd1}},
      '{MODE_CREATE, '0, '0, 1'b1, '{ST_OK, 10'd1, 16'd1, 11'd2}},
      '{MODE_VALIDATE, 10'd0, 16'd1, 1'b1, '{ST_OK, 10'd0, 16'd1, 11'd2}},
      '{MODE_VALIDATE, 10'd0, 16'd0, 1'b1, '{ST_INVALID, '0, '0, 11'd2}},
      '{MODE_VALIDATE, 10'd0, 16'd2, 1'b0, UNTYPED},
      '{MODE_LOOKUP, 10'd1, '0, 1'b1, '{ST_OK, 10'd1, 16'd1, 11'd2}},
      // index never handed out
      '{MODE_LOOKUP, 10'd2, '0, 1'b1, '{ST_INVALID, '0, '0, 11'd2}},
      '{MODE_DESTROY, 10'd0, 16'd1, 1'b1, '{ST_OK, 10'd0, 16'd2, 11'd1}},
      // stale handle after destroy, freed slot still looks up
      '{MODE_VALIDATE, 10'd0, 16'd1, 1'b1, '{ST_INVALID, '0, '0, 11'd1}},
      '{MODE_LOOKUP, 10'd0, '0, 1'b1, '{ST_OK, 10'd0, 16'd2, 11'd1}},
      '{MODE_CREATE, '0, '0, 1'b1, '{ST_OK, 10'd0, 16'd2, 11'd2}},
      // unused modes
      '{MODE_SPARE5, 10'd1, 16'd1, 1'b1, '{ST_INVALID, '0, '0, 11'd2}},
      '{MODE_SPARE7, IDX_TOP, GEN_TOP, 1'b1, '{ST_INVALID, '0, '0, 11'd2}},
      // live slot destroyed, then destroyed again once freed, also with no live handles left
      '{MODE_DESTROY, 10'd1, 16'd1, 1'b0, UNTYPED},
      '{MODE_DESTROY, 10'd1, 16'd2, 1'b0, UNTYPED},
      '{MODE_DESTROY, 10'd1, 16'd3, 1'b0, UNTYPED},
      '{MODE_CREATE, '0, '0, 1'b0, UNTYPED},
      '{MODE_CREATE, '0, '0, 1'b0, UNTYPED},
      // clear empties everything
      '{MODE_CLEAR, IDX_TOP, GEN_TOP, 1'b1, '{ST_OK, '0, '0, '0}},
      '{MODE_LOOKUP, '0, '0, 1'b1, '{ST_INVALID, '0, '0, '0}},
      '{MODE_CREATE, '0, '0, 1'b1, '{ST_OK, 10'd0, 16'd1, 11'd1}},
      '{MODE_SPARE6, '0, '0, 1'b1, '{ST_INVALID, '0, '0, 11'd1}}
    };

    // reset
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words at the reset max_generation
    for (k = 0; k < DIR_N; k++) send_word(dir_rows[k]);

    // small max_generation, no idling
    write_max_gen(16'd3);
    random_batch(RAND_PER_PHASE);

    // every bump gives one, sender mostly idle
    write_max_gen(16'd1);
    send_idle_pct = 77;
    random_batch(RAND_PER_PHASE);

    // widest max_generation, receiver mostly stalled
    write_max_gen(GEN_TOP);
    send_idle_pct = 0;
    stall_pct = 77;
    random_batch(RAND_PER_PHASE);

    // zero max_generation, light idling on both sides
    write_max_gen(16'd0);
    send_idle_pct = 17;
    stall_pct = 17;
    random_batch(RAND_PER_PHASE);

    // stress at the widest max_generation, no idling
    write_max_gen(GEN_TOP);
    send_idle_pct = 0;
    stall_pct = 0;

    // fill the table, then run into the full case
    send_word(op_row(MODE_CLEAR, '0, '0));
    for (k = 0; k < SLOTS + 2; k++) send_word(op_row(MODE_CREATE, IW'($urandom), '0));
    send_word(op_row(MODE_LOOKUP, IDX_TOP, '0));
    send_word(op_row(MODE_VALIDATE, IDX_TOP, GEN_FIRST));
    send_word(op_row(MODE_DESTROY, IDX_TOP, GEN_FIRST));
    send_word(op_row(MODE_CREATE, '0, '0));
    send_word(op_row(MODE_CREATE, '0, '0));
    send_idle_pct = 17;
    stall_pct = 17;
    random_batch(40);

    // drain and report
    stall_pct = 0;
    wait_idle();
    if (bad_words == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
